### design/fha_pkg.sv
// Shared types, widths and codes of the feature histogram accumulator.
package fha_pkg;

  localparam int REQ_W      = 2;
  localparam int FEAT_W     = 6;
  localparam int SAMPLE_W   = 32;
  localparam int SEL_W      = 7;
  localparam int COUNT_W    = 32;
  localparam int RS_W       = 21;
  localparam int BW_W       = 16;
  localparam int DIFF_W     = SAMPLE_W + 1;
  // Bucket numbers inside the block cover up to 1024 buckets.
  localparam int BKT_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RS_W;

  localparam logic signed [RS_W-1:0] RANGE_START_RST  = -21'sd2977;
  localparam logic [BW_W-1:0]        BUCKET_WIDTH_RST = 16'd46;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_START  = 1'b0,
    CFG_BUCKET_WIDTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_INC,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLASS,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic              hit;
    logic [FEAT_W-1:0] feat;
    logic [BKT_W-1:0]  bucket;
    logic              clamped;
  } cmd_t;

endpackage

### design/fha_if.sv
// Request and response channel interfaces of the feature histogram accumulator.
interface fha_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [fha_pkg::REQ_W-1:0]        req_type;
  logic        [fha_pkg::FEAT_W-1:0]       feature_index;
  logic signed [fha_pkg::SAMPLE_W-1:0]     sample_milli;
  logic        [fha_pkg::SEL_W-1:0]        bucket_select;

  modport source (output valid, req_type, feature_index, sample_milli, bucket_select,
                  input ready);
  modport sink   (input valid, req_type, feature_index, sample_milli, bucket_select,
                  output ready);
endinterface

interface fha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fha_pkg::SEL_W-1:0]     bucket_index;
  logic [fha_pkg::COUNT_W-1:0]   bucket_count;
  logic                          was_clamped;

  modport source (output valid, bucket_index, bucket_count, was_clamped, input ready);
  modport sink   (input valid, bucket_index, bucket_count, was_clamped, output ready);
endinterface

### design/fha_front.sv
// Front end: accepts requests, finds the bucket of a sample and issues commands.
module fha_front #(
  parameter int NUM_FEATURES = 64,
  parameter int HIST_BUCKETS = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fha_req_if.sink                          req_i,
  input  logic signed [fha_pkg::RS_W-1:0]  range_start_i,
  input  logic        [fha_pkg::BW_W-1:0]  bucket_width_i,
  input  logic                             clear_busy_i,
  output logic                             cmd_valid_o,
  input  logic                             cmd_ready_i,
  output fha_pkg::cmd_t                    cmd_o
);
  import fha_pkg::*;

  localparam int QB = $clog2(HIST_BUCKETS);
  localparam int DW = QB + BW_W;
  localparam int CW = $clog2(QB + 1);

  front_state_e state_q, state_d;

  op_e                op_q, op_dec;
  logic [FEAT_W-1:0]  feat_q;
  logic [SEL_W-1:0]   sel_q;
  logic [DIFF_W-1:0]  diff_q, diff_d;
  logic [DW-1:0]      limit_q, rem_q, dsr_q, rem_d;
  logic [QB-1:0]      quo_q, quo_d;
  logic [CW-1:0]      cnt_q;
  cmd_t               cmd_q;

  logic [BW_W-1:0]    wv;
  logic [DIFF_W-1:0]  lo_sum;
  logic               take, feat_ok, sel_ok, is_neg, low_clamp, over, need_div, ge;

  always_comb begin
    unique case (req_i.req_type)
      REQ_ADD:   op_dec = OP_INC;
      REQ_CLEAR: op_dec = OP_CLEAR;
      default:   op_dec = OP_READ;
    endcase
  end

  // Zero width counts as one
  assign wv      = (bucket_width_i == '0) ? BW_W'(1) : bucket_width_i;
  assign diff_d  = {req_i.sample_milli[SAMPLE_W-1], req_i.sample_milli}
                 - {{(DIFF_W-RS_W){range_start_i[RS_W-1]}}, range_start_i};
  assign feat_ok = 32'(feat_q) < 32'(NUM_FEATURES);
  assign sel_ok  = 32'(sel_q) < 32'(HIST_BUCKETS);
  assign is_neg  = diff_q[DIFF_W-1];
  // Truncation toward zero: only a difference at or below minus one width clamps low
  assign lo_sum    = diff_q + DIFF_W'(wv);
  assign low_clamp = lo_sum[DIFF_W-1] | (lo_sum == '0);
  assign over      = !is_neg && (diff_q >= DIFF_W'(limit_q));
  assign need_div  = (op_q == OP_INC) && !is_neg && !over;

  assign ge    = rem_q >= dsr_q;
  assign rem_d = ge ? rem_q - dsr_q : rem_q;
  assign quo_d = QB'({quo_q, ge});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (take) state_d = F_CLASS;
      F_CLASS: state_d = need_div ? F_DIV : F_PUSH;
      F_DIV:   if (cnt_q == CW'(1)) state_d = F_PUSH;
      F_PUSH:  if (cmd_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_i.ready = (state_q == F_IDLE) && !clear_busy_i;
    cmd_valid_o = (state_q == F_PUSH);
  end

  assign take  = req_i.valid && req_i.ready;
  assign cmd_o = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= DW'(wv) * DW'(HIST_BUCKETS);
    case (state_q)
      F_IDLE: begin
        if (take) begin
          op_q   <= op_dec;
          feat_q <= req_i.feature_index;
          sel_q  <= req_i.bucket_select;
          diff_q <= diff_d;
        end
      end
      F_CLASS: begin
        cmd_q.op   <= op_q;
        cmd_q.feat <= feat_q;
        rem_q      <= DW'(diff_q);
        dsr_q      <= DW'(wv) << (QB - 1);
        quo_q      <= '0;
        cnt_q      <= CW'(QB);
        if (op_q != OP_INC) begin
          cmd_q.hit     <= feat_ok && sel_ok;
          cmd_q.bucket  <= BKT_W'(sel_q);
          cmd_q.clamped <= 1'b0;
        end else if (is_neg) begin
          cmd_q.hit     <= feat_ok;
          cmd_q.bucket  <= '0;
          cmd_q.clamped <= low_clamp;
        end else begin
          cmd_q.hit     <= feat_ok;
          cmd_q.bucket  <= BKT_W'(HIST_BUCKETS - 1);
          cmd_q.clamped <= over;
        end
      end
      F_DIV: begin
        rem_q        <= rem_d;
        dsr_q        <= dsr_q >> 1;
        quo_q        <= quo_d;
        cnt_q        <= cnt_q - CW'(1);
        cmd_q.bucket <= BKT_W'(quo_d);
      end
      default: ;
    endcase
  end

  a_clamp_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && cmd_q.clamped |-> cmd_q.op == OP_INC)
    else $error("clamped flag on a read command");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_DIV |-> cnt_q != '0)
    else $error("divider running with no steps left");

  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !clear_busy_i)
    else $error("request taken during clearing pass");

endmodule

### design/fha_fifo.sv
// Two-entry command queue between the front end and the counter engine.
module fha_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fha_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fha_pkg::cmd_t pop_data_o
);
  import fha_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### design/fha_back.sv
// Counter engine: clears the counter store, then runs read-modify-write commands.
module fha_back #(
  parameter int NUM_FEATURES = 64,
  parameter int HIST_BUCKETS = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  fha_pkg::cmd_t pop_data_i,
  output logic          clear_busy_o,
  fha_rsp_if.source     rsp_o
);
  import fha_pkg::*;

  localparam int DEPTH = NUM_FEATURES * HIST_BUCKETS;
  localparam int AW    = $clog2(DEPTH);

  back_state_e state_q, state_d;

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rdata_q;
  logic [AW-1:0]      clr_q, cur_addr_q, rd_addr, wr_addr;
  cmd_t               cur_q;

  logic               rsp_valid_q;
  logic [SEL_W-1:0]   idx_q;
  logic [COUNT_W-1:0] count_q;
  logic               clamp_q;

  logic               pop, out_free, fire, clr_last;
  logic               op_we, mem_we;
  logic [COUNT_W-1:0] new_count, op_wdata, mem_wdata;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign clr_last = (clr_q == AW'(DEPTH - 1));
  assign rd_addr  = AW'(pop_data_i.feat) * AW'(HIST_BUCKETS) + AW'(pop_data_i.bucket);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: if (clr_last) state_d = B_IDLE;
      B_IDLE:  if (pop_valid_i) state_d = B_EXEC;
      B_EXEC:  if (out_free) state_d = B_IDLE;
      default: state_d = B_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    clear_busy_o = (state_q == B_CLEAR);
    pop          = (state_q == B_IDLE) && pop_valid_i;
    fire         = (state_q == B_EXEC) && out_free;
  end

  assign pop_ready_o = pop;

  // Saturating increment, read, or read and zero
  always_comb begin
    new_count = rdata_q;
    op_we     = 1'b0;
    op_wdata  = '0;
    unique case (cur_q.op)
      OP_INC: begin
        if (!(&rdata_q)) new_count = rdata_q + COUNT_W'(1);
        op_we    = 1'b1;
        op_wdata = new_count;
      end
      OP_CLEAR: op_we = 1'b1;
      default: ;
    endcase
    if (!cur_q.hit) begin
      new_count = '0;
      op_we     = 1'b0;
    end
  end

  assign mem_we    = clear_busy_o || (fire && op_we);
  assign wr_addr   = clear_busy_o ? clr_q : cur_addr_q;
  assign mem_wdata = clear_busy_o ? '0 : op_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= mem_wdata;
    if (pop)    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_busy_o) clr_q <= clr_q + AW'(1);
      if (fire)              rsp_valid_q <= 1'b1;
      else if (rsp_o.ready)  rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q      <= pop_data_i;
      cur_addr_q <= rd_addr;
    end
    if (fire) begin
      idx_q   <= cur_q.bucket[SEL_W-1:0];
      count_q <= new_count;
      clamp_q <= cur_q.clamped;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.bucket_index = idx_q;
  assign rsp_o.bucket_count = count_q;
  assign rsp_o.was_clamped  = clamp_q;

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CLEAR |-> !pop)
    else $error("command taken during clearing pass");

  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cur_q.op == OP_READ |-> !mem_we)
    else $error("plain read wrote the counter store");

  a_hold_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EXEC && rsp_valid_q && !rsp_o.ready |=> state_q == B_EXEC)
    else $error("command retired while response slot was full");

endmodule

### design/feature_histogram_accumulator_core.sv
// Top level of the per-feature clamped histogram accumulator.
//
//  channel  dir  handshake            payload
//  req_i    in   valid/ready          req_type, feature_index, sample_milli, bucket_select
//  rsp_o    out  valid/ready          bucket_index, bucket_count, was_clamped
//  cfg      in   cfg_we_i (no stall)  cfg_idx_i, cfg_data_i
//
//  Reads, clears and adds whose difference is negative or past the range skip the divider in
//  the front end; other adds also pass through the bit-a-cycle divider.
//  The counter engine reads memory, then writes and responds when the output is free.
//  After reset a clearing pass zeroes all NUM_FEATURES * HIST_BUCKETS counters (8192 by
//  default); no request is taken until it ends.
//  A stalled response holds in its register; the two-entry queue lets the front end go on.
module feature_histogram_accumulator_core #(
  parameter int NUM_FEATURES = 64,
  parameter int HIST_BUCKETS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fha_req_if.sink                           req_i,
  fha_rsp_if.source                         rsp_o,
  input  logic                              cfg_we_i,
  input  logic [fha_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fha_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import fha_pkg::*;

  logic signed [RS_W-1:0] range_start_q;
  logic [BW_W-1:0]        bucket_width_q;

  logic clear_busy;
  logic cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q  <= RANGE_START_RST;
      bucket_width_q <= BUCKET_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_RANGE_START:  range_start_q  <= $signed(cfg_data_i[RS_W-1:0]);
        CFG_BUCKET_WIDTH: bucket_width_q <= cfg_data_i[BW_W-1:0];
        default: ;
      endcase
    end
  end

  fha_front #(
    .NUM_FEATURES (NUM_FEATURES),
    .HIST_BUCKETS (HIST_BUCKETS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .range_start_i  (range_start_q),
    .bucket_width_i (bucket_width_q),
    .clear_busy_i   (clear_busy),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  fha_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  fha_back #(
    .NUM_FEATURES (NUM_FEATURES),
    .HIST_BUCKETS (HIST_BUCKETS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (q_valid),
    .pop_ready_o  (q_ready),
    .pop_data_i   (q_cmd),
    .clear_busy_o (clear_busy),
    .rsp_o        (rsp_o)
  );

endmodule
